// File: rtl/core/btc_pkg.sv
// Shared types, constants and helpers for the Boolean tensor-train compose core.
package btc_pkg;

  localparam int ADDR_W = 16;

  localparam logic [1:0] CMD_WR_FIRST  = 2'd0;
  localparam logic [1:0] CMD_WR_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPOSE   = 2'd2;
  localparam logic [1:0] CMD_RD_OUT    = 2'd3;

  localparam logic [1:0] REG_CHAIN_LENGTH = 2'd0;
  localparam logic [1:0] REG_FIRST_RANK   = 2'd1;
  localparam logic [1:0] REG_SECOND_RANK  = 2'd2;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam int          FNV_SHIFT    = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] cell_address;
    logic        bit_value;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        read_bit;
    logic [11:0] ones_count;
    logic [12:0] shared_reads;
    logic [63:0] output_hash;
  } out_word_t;

  typedef struct packed {
    logic init;
    logic step;
    logic y;
  } walk_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [ADDR_W-1:0] oaddr;
    logic              last;
  } walk_pos_t;

  // 8r + 4(len-2)r^2
  function automatic logic [ADDR_W-1:0] cell_count(input logic [4:0] len,
                                                   input logic [4:0] r);
    logic [ADDR_W-1:0] rr;
    logic [ADDR_W-1:0] l2;
    rr = ADDR_W'(r) * ADDR_W'(r);
    l2 = ADDR_W'(len) - ADDR_W'(2);
    return (ADDR_W'(r) << 3) + ((l2 * rr) << 2);
  endfunction

endpackage

// File: rtl/core/boolean_tt_core_compose_core.sv
// Top level: command decode, chain stores, compose sequencer and result register.
// Write commands: result strobe in the cycle after start, busy stays low.
// Read command: result after the S_RDOUT state, busy for one cycle.
// Compose: states S_CRD0, S_CRD1, S_CACC, S_CMIX per product cell (two store reads, combine,
//   hash mix) over 8r+4(len-2)r^2 cells with r the output rank, then S_CFIN; busy throughout.
// Synchronous active-high reset restores the register defaults and idles the
//   sequencer; store contents are undefined until written.
module boolean_tt_core_compose_core #(
  parameter int MAX_SITES       = 16,
  parameter int MAX_FIRST_RANK  = 4,
  parameter int MAX_SECOND_RANK = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  btc_pkg::in_word_t    in_word,
  output logic                 out_valid,
  output btc_pkg::out_word_t   out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW = btc_pkg::ADDR_W;
  localparam int D1 = 8 * MAX_FIRST_RANK + 4 * (MAX_SITES - 2) * MAX_FIRST_RANK * MAX_FIRST_RANK;
  localparam int D2 = 8 * MAX_SECOND_RANK
                    + 4 * (MAX_SITES - 2) * MAX_SECOND_RANK * MAX_SECOND_RANK;
  localparam int RO = MAX_FIRST_RANK * MAX_SECOND_RANK;
  localparam int DP = 8 * RO + 4 * (MAX_SITES - 2) * RO * RO;
  localparam int I1W = $clog2(D1);
  localparam int I2W = $clog2(D2);
  localparam int IPW = $clog2(DP);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDOUT = 7'b0000010,
    S_CRD0  = 7'b0000100,
    S_CRD1  = 7'b0001000,
    S_CACC  = 7'b0010000,
    S_CMIX  = 7'b0100000,
    S_CFIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [4:0] chain_length;
  logic [2:0] first_rank;
  logic [1:0] second_rank;

  logic mem1 [D1];
  logic mem2 [D2];
  logic memp [DP];
  logic rd1_q, rd2_q, rdp_q;
  logic prod0;
  logic rd_ok;
  logic [11:0] ones;

  btc_pkg::walk_ctl_t walk_ctl;
  btc_pkg::walk_pos_t pos;
  logic [63:0] hash;
  logic        v;

  logic          accept;
  logic [AW-1:0] addr_ext;
  logic [AW-1:0] cells1, cells2, cellsp;
  logic          ok1, ok2, okp;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign addr_ext  = AW'(in_word.cell_address);
  assign cells1    = btc_pkg::cell_count(chain_length, 5'(first_rank));
  assign cells2    = btc_pkg::cell_count(chain_length, 5'(second_rank));
  assign cellsp    = btc_pkg::cell_count(chain_length, 5'(first_rank) * 5'(second_rank));
  assign ok1       = (addr_ext < cells1) && (32'(in_word.cell_address) < D1);
  assign ok2       = (addr_ext < cells2) && (32'(in_word.cell_address) < D2);
  assign okp       = (addr_ext < cellsp) && (32'(in_word.cell_address) < DP);
  assign v         = prod0 | (rd1_q & rd2_q);

  always_comb begin
    walk_ctl.init = accept && (in_word.command == btc_pkg::CMD_COMPOSE);
    walk_ctl.step = (state == S_CMIX) && !pos.last;
    walk_ctl.y    = (state == S_CRD1);
  end

  btc_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .ctl          (walk_ctl),
    .chain_length (chain_length),
    .first_rank   (first_rank),
    .second_rank  (second_rank),
    .pos          (pos)
  );

  btc_hash u_hash (
    .clk    (clk),
    .init   (walk_ctl.init),
    .absorb (state == S_CACC),
    .mix    (state == S_CMIX),
    .bit_in (v),
    .hash   (hash)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_word.command == btc_pkg::CMD_COMPOSE) begin
          state_next = S_CRD0;
        end else if (accept && in_word.command == btc_pkg::CMD_RD_OUT) begin
          state_next = S_RDOUT;
        end
      end
      S_RDOUT: state_next = S_IDLE;
      S_CRD0:  state_next = S_CRD1;
      S_CRD1:  state_next = S_CACC;
      S_CACC:  state_next = S_CMIX;
      S_CMIX:  state_next = pos.last ? S_CFIN : S_CRD0;
      S_CFIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      chain_length <= 5'd4;
      first_rank   <= 3'd2;
      second_rank  <= 2'd2;
    end else begin
      state     <= state_next;
      out_valid <= (accept && (in_word.command == btc_pkg::CMD_WR_FIRST ||
                               in_word.command == btc_pkg::CMD_WR_SECOND))
                   || state == S_RDOUT || state == S_CFIN;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          btc_pkg::REG_CHAIN_LENGTH: begin
            if (cfg_data[4:0] < 5'd4) begin
              chain_length <= 5'd4;
            end else if (32'(cfg_data[4:0]) > MAX_SITES) begin
              chain_length <= 5'(MAX_SITES);
            end else begin
              chain_length <= cfg_data[4:0];
            end
          end
          btc_pkg::REG_FIRST_RANK: begin
            if (cfg_data[2:0] == 3'd0) begin
              first_rank <= 3'd1;
            end else if (32'(cfg_data[2:0]) > MAX_FIRST_RANK) begin
              first_rank <= 3'(MAX_FIRST_RANK);
            end else begin
              first_rank <= cfg_data[2:0];
            end
          end
          btc_pkg::REG_SECOND_RANK: begin
            if (cfg_data[1:0] == 2'd0) begin
              second_rank <= 2'd1;
            end else if (32'(cfg_data[1:0]) > MAX_SECOND_RANK) begin
              second_rank <= 2'(MAX_SECOND_RANK);
            end else begin
              second_rank <= cfg_data[1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (accept && in_word.command == btc_pkg::CMD_WR_FIRST && ok1) begin
      mem1[in_word.cell_address[I1W-1:0]] <= in_word.bit_value;
    end
    if (accept && in_word.command == btc_pkg::CMD_WR_SECOND && ok2) begin
      mem2[in_word.cell_address[I2W-1:0]] <= in_word.bit_value;
    end
    if (state == S_CACC) begin
      memp[pos.oaddr[IPW-1:0]] <= v;
    end
    rd1_q <= mem1[pos.addr1[I1W-1:0]];
    rd2_q <= mem2[pos.addr2[I2W-1:0]];
    rdp_q <= memp[in_word.cell_address[IPW-1:0]];
  end

  // datapath and result word
  always_ff @(posedge clk) begin
    if (state == S_CRD1) begin
      prod0 <= rd1_q & rd2_q;
    end
    if (walk_ctl.init) begin
      ones <= '0;
    end else if (state == S_CACC) begin
      ones <= ones + 12'(v);
    end
    if (accept) begin
      rd_ok    <= okp;
      out_word <= '0;
      case (in_word.command)
        btc_pkg::CMD_WR_FIRST:  out_word.status <= !ok1;
        btc_pkg::CMD_WR_SECOND: out_word.status <= !ok2;
        default: begin
        end
      endcase
    end else if (state == S_RDOUT) begin
      out_word.status   <= !rd_ok;
      out_word.read_bit <= rd_ok & rdp_q;
    end else if (state == S_CFIN) begin
      out_word.status       <= 1'b0;
      out_word.read_bit     <= 1'b0;
      out_word.ones_count   <= ones;
      out_word.shared_reads <= 13'((pos.oaddr + AW'(1)) << 1);
      out_word.output_hash  <= hash;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || busy))
    else $error("accepted word produced neither result nor busy");

  assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.command == btc_pkg::CMD_COMPOSE) |=> state == S_CRD0)
    else $error("compose did not start walk");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status) |-> (out_word.ones_count == 12'd0 &&
                                        out_word.output_hash == 64'd0))
    else $error("error status with compose payload");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CFIN) |=> (out_valid && state == S_IDLE))
    else $error("compose finish without result");

endmodule

// File: rtl/core/btc_walk.sv
// Cell walker: product cell counters and operand address generation.
module btc_walk (
  input  logic                   clk,
  input  logic                   rst,
  input  btc_pkg::walk_ctl_t     ctl,
  input  logic [4:0]             chain_length,
  input  logic [2:0]             first_rank,
  input  logic [1:0]             second_rank,
  output btc_pkg::walk_pos_t     pos
);

  localparam int AW = btc_pkg::ADDR_W;

  logic [4:0]    site;
  logic [2:0]    a;
  logic [1:0]    c;
  logic          x;
  logic          z;
  logic [2:0]    b;
  logic [1:0]    d;
  logic [AW-1:0] base1;
  logic [AW-1:0] base2;
  logic [AW-1:0] oaddr;

  logic          first_site, last_site;
  logic [2:0]    la, ra;
  logic [1:0]    lb, rb;
  logic          a_wrap, b_wrap, c_wrap, d_wrap;
  logic [AW-1:0] inc1, inc2;

  always_comb begin
    first_site = (site == 5'd0);
    last_site  = (site == chain_length - 5'd1);
    la = first_site ? 3'd1 : first_rank;
    lb = first_site ? 2'd1 : second_rank;
    ra = last_site ? 3'd1 : first_rank;
    rb = last_site ? 2'd1 : second_rank;
    a_wrap = (a == la - 3'd1);
    c_wrap = (c == lb - 2'd1);
    b_wrap = (b == ra - 3'd1);
    d_wrap = (d == rb - 2'd1);
    inc1 = first_site ? (AW'(first_rank) << 2)
                      : ((AW'(first_rank) * AW'(first_rank)) << 2);
    inc2 = first_site ? (AW'(second_rank) << 2)
                      : ((AW'(second_rank) * AW'(second_rank)) << 2);
    pos.addr1 = base1 + AW'(8'({a, x, ctl.y}) * 8'(ra)) + AW'(b);
    pos.addr2 = base2 + AW'(8'({c, ctl.y, z}) * 8'(rb)) + AW'(d);
    pos.oaddr = oaddr;
    pos.last  = last_site & a_wrap & c_wrap & x & z & b_wrap & d_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      site  <= '0;
      a     <= '0;
      c     <= '0;
      x     <= 1'b0;
      z     <= 1'b0;
      b     <= '0;
      d     <= '0;
      base1 <= '0;
      base2 <= '0;
      oaddr <= '0;
    end else if (ctl.step) begin
      oaddr <= oaddr + AW'(1);
      if (!d_wrap) begin
        d <= d + 2'd1;
      end else begin
        d <= '0;
        if (!b_wrap) begin
          b <= b + 3'd1;
        end else begin
          b <= '0;
          if (!z) begin
            z <= 1'b1;
          end else begin
            z <= 1'b0;
            if (!x) begin
              x <= 1'b1;
            end else begin
              x <= 1'b0;
              if (!c_wrap) begin
                c <= c + 2'd1;
              end else begin
                c <= '0;
                if (!a_wrap) begin
                  a <= a + 3'd1;
                end else begin
                  a     <= '0;
                  site  <= site + 5'd1;
                  base1 <= base1 + inc1;
                  base2 <= base2 + inc2;
                end
              end
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/btc_hash.sv
// FNV-1a 64 unit: xor and low-constant multiply on absorb, then shifted add on mix.
module btc_hash (
  input  logic        clk,
  input  logic        init,
  input  logic        absorb,
  input  logic        mix,
  input  logic        bit_in,
  output logic [63:0] hash
);

  logic [63:0] h;
  logic [63:0] hx;
  logic [63:0] t;
  logic [63:0] hx_next;

  assign hx_next = h ^ {63'd0, bit_in};
  assign hash    = h;

  always_ff @(posedge clk) begin
    if (init) begin
      h <= btc_pkg::FNV_BASIS;
    end else if (mix) begin
      h <= t + (hx << btc_pkg::FNV_SHIFT);
    end
    if (absorb) begin
      hx <= hx_next;
      t  <= hx_next * 64'(btc_pkg::FNV_PRIME_LO);
    end
  end

endmodule

// File: test/testbench.sv
// Testbench for the Boolean tensor-train compose core: queued commands, predicted results.
`timescale 1ns / 1ps
module testbench;

  typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;
  typedef struct {
    op_kind_t           kind;
    btc_pkg::in_word_t  word;
    logic [1:0]         idx;
    logic [7:0]         data;
  } op_t;

  logic               clk, rst, start, busy, out_valid, cfg_valid, cfg_ready;
  btc_pkg::in_word_t  in_word;
  btc_pkg::out_word_t out_word;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  boolean_tt_core_compose_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  op_t                op_q[$];
  btc_pkg::out_word_t expected_q[$];
  int                 issued, received, errors, cyc;

  // predictor state
  int   p_len, p_r1, p_r2;
  logic first_st[1024];
  logic second_st[256];
  logic prod_st[4096];

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int cells_of(int len, int r);
    return 8 * r + 4 * (len - 2) * r * r;
  endfunction

  function automatic int cell_at(int len, int r, int site, int left, int x, int y, int right);
    int rr;
    int base;
    rr = (site + 1 == len) ? 1 : r;
    base = (site == 0) ? 0 : 4 * r + (site - 1) * 4 * r * r;
    return base + ((left * 2 + x) * 2 + y) * rr + right;
  endfunction

  function automatic btc_pkg::out_word_t compose_chains();
    btc_pkg::out_word_t res;
    int          ro, la, lb, ra, rb, n, cnt, oi;
    logic        v;
    logic [63:0] h;
    ro = p_r1 * p_r2;
    n = 0;
    cnt = 0;
    h = btc_pkg::FNV_BASIS;
    for (int s = 0; s < p_len; s++) begin
      la = (s == 0) ? 1 : p_r1;
      lb = (s == 0) ? 1 : p_r2;
      ra = (s + 1 == p_len) ? 1 : p_r1;
      rb = (s + 1 == p_len) ? 1 : p_r2;
      for (int a = 0; a < la; a++)
        for (int c = 0; c < lb; c++)
          for (int x = 0; x < 2; x++)
            for (int z = 0; z < 2; z++)
              for (int b = 0; b < ra; b++)
                for (int d = 0; d < rb; d++) begin
                  v = 1'b0;
                  for (int y = 0; y < 2; y++) begin
                    v = v | (first_st[cell_at(p_len, p_r1, s, a, x, y, b)] &
                             second_st[cell_at(p_len, p_r2, s, c, y, z, d)]);
                    n++;
                  end
                  oi = cell_at(p_len, ro, s, a * lb + c, x, z, b * rb + d);
                  if (oi < 4096) prod_st[oi] = v;
                end
    end
    for (int i = 0; i < cells_of(p_len, ro) && i < 4096; i++) begin
      cnt += prod_st[i];
      h = (h ^ 64'(prod_st[i])) * 64'd1099511628211;
    end
    res = '0;
    res.ones_count = 12'(cnt);
    res.shared_reads = 13'(n);
    res.output_hash = h;
    return res;
  endfunction

  function automatic btc_pkg::out_word_t predict_word(btc_pkg::in_word_t w);
    btc_pkg::out_word_t res;
    int        a;
    res = '0;
    a = w.cell_address;
    case (w.command)
      btc_pkg::CMD_WR_FIRST: begin
        if (a < cells_of(p_len, p_r1)) first_st[a] = w.bit_value;
        else res.status = 1'b1;
      end
      btc_pkg::CMD_WR_SECOND: begin
        if (a < cells_of(p_len, p_r2)) second_st[a] = w.bit_value;
        else res.status = 1'b1;
      end
      btc_pkg::CMD_COMPOSE: res = compose_chains();
      default: begin
        if (a < cells_of(p_len, p_r1 * p_r2)) res.read_bit = prod_st[a];
        else res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    logic     nx_start, nx_cfg, acc, cfg_done, idle;
    btc_pkg::in_word_t nx_word;
    logic [1:0] nx_idx;
    logic [7:0] nx_data;
    nx_start = start;
    nx_cfg = cfg_valid;
    nx_word = in_word;
    nx_idx = cfg_index;
    nx_data = cfg_data;
    if (rst) begin
      nx_start = 1'b0;
      nx_cfg = 1'b0;
    end else begin
      acc = start && !busy;
      cfg_done = cfg_valid && cfg_ready;
      idle = !(cyc >= 3000 && cyc < 9000) && ($urandom_range(0, 99) < 35);
      if (acc) begin
        expected_q.push_back(predict_word(in_word));
        issued <= issued + 1;
      end
      if (cfg_done) begin
        case (cfg_index)
          btc_pkg::REG_CHAIN_LENGTH: p_len = clampi(cfg_data & 8'h1f, 4, 16);
          btc_pkg::REG_FIRST_RANK:   p_r1 = clampi(cfg_data & 8'h07, 1, 4);
          btc_pkg::REG_SECOND_RANK:  p_r2 = clampi(cfg_data & 8'h03, 1, 2);
          default: ;
        endcase
      end
      if ((start && !acc) || (cfg_valid && !cfg_done)) begin
      end else begin
        nx_start = 1'b0;
        nx_cfg = 1'b0;
        if (op_q.size() > 0) begin
          case (op_q[0].kind)
            OP_WORD: if (!idle) begin
              nx_start = 1'b1;
              nx_word = op_q[0].word;
              void'(op_q.pop_front());
            end
            OP_CFG: if (!acc && !busy && issued == received && !out_valid) begin
              nx_cfg = 1'b1;
              nx_idx = op_q[0].idx;
              nx_data = op_q[0].data;
              void'(op_q.pop_front());
            end
            default: if (!acc && issued == received && !out_valid)
              void'(op_q.pop_front());
          endcase
        end
      end
    end
    start <= nx_start;
    cfg_valid <= nx_cfg;
    in_word <= nx_word;
    cfg_index <= nx_idx;
    cfg_data <= nx_data;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("word %0d: %s got %0h expected %0h", received, what, got, want);
    errors++;
  endtask

  // monitor and watchdog
  int stall;
  always @(posedge clk) begin
    btc_pkg::out_word_t e;
    cyc <= cyc + 1;
    if (rst) begin
      stall <= 0;
    end else begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) stall <= 0;
      else if (stall >= 200000) begin
        $display("Mismatches found");
        $finish;
      end else stall <= stall + 1;
      if (out_valid) begin
        received <= received + 1;
        if (expected_q.size() == 0) begin
          report("unexpected word", 64'(out_word.status), 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_word.status !== e.status) report("status", out_word.status, e.status);
          if (out_word.read_bit !== e.read_bit) report("read_bit", out_word.read_bit, e.read_bit);
          if (out_word.ones_count !== e.ones_count)
            report("ones_count", out_word.ones_count, e.ones_count);
          if (out_word.shared_reads !== e.shared_reads)
            report("shared_reads", out_word.shared_reads, e.shared_reads);
          if (out_word.output_hash !== e.output_hash)
            report("output_hash", out_word.output_hash, e.output_hash);
        end
      end
    end
  end

  // stimulus generation, with a shadow of the configuration
  int g_len, g_r1, g_r2, g_items;

  task automatic add_word(logic [1:0] cmd, int addr, logic b);
    op_t o;
    o.kind = OP_WORD;
    o.word.command = cmd;
    o.word.cell_address = 12'(addr);
    o.word.bit_value = b;
    o.idx = '0;
    o.data = '0;
    op_q.push_back(o);
    g_items++;
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [7:0] data);
    op_t o;
    o.kind = OP_CFG;
    o.word = '0;
    o.idx = idx;
    o.data = data;
    op_q.push_back(o);
    case (idx)
      btc_pkg::REG_CHAIN_LENGTH: g_len = clampi(data & 8'h1f, 4, 16);
      btc_pkg::REG_FIRST_RANK:   g_r1 = clampi(data & 8'h07, 1, 4);
      default:                   g_r2 = clampi(data & 8'h03, 1, 2);
    endcase
  endtask

  task automatic add_drain();
    op_t o;
    o.kind = OP_DRAIN;
    o.word = '0;
    o.idx = '0;
    o.data = '0;
    op_q.push_back(o);
  endtask

  function automatic logic pick_bit(int mode);
    return mode == 1 ? 1'b1 : (mode == 2 ? 1'b0 : 1'($urandom));
  endfunction

  // load both chains fully plus out-of-range writes, compose, then reads with noise, a recompose and more reads
  task automatic run_phase(int mode, int n_reads);
    int c1, c2, co;
    c1 = cells_of(g_len, g_r1);
    c2 = cells_of(g_len, g_r2);
    co = cells_of(g_len, g_r1 * g_r2);
    for (int i = 0; i < c1; i++) add_word(btc_pkg::CMD_WR_FIRST, i, pick_bit(mode));
    for (int i = 0; i < c2; i++) add_word(btc_pkg::CMD_WR_SECOND, i, pick_bit(mode));
    add_word(btc_pkg::CMD_WR_FIRST, $urandom_range(c1, 4095), 1'($urandom));
    add_word(btc_pkg::CMD_WR_SECOND, $urandom_range(c2, 4095), 1'($urandom));
    add_word(btc_pkg::CMD_COMPOSE, $urandom_range(0, 4095), 1'($urandom));
    for (int i = 0; i < n_reads; i++) begin
      case ($urandom_range(0, 9))
        0: add_word(btc_pkg::CMD_WR_FIRST, $urandom_range(0, c1 - 1), pick_bit(mode));
        1: add_word(btc_pkg::CMD_WR_SECOND, $urandom_range(0, c2 - 1), pick_bit(mode));
        2: add_word(btc_pkg::CMD_RD_OUT, $urandom_range(co, 4095), 1'($urandom));
        3: add_word(btc_pkg::CMD_WR_FIRST, $urandom_range(0, 4095), 1'($urandom));
        default: add_word(btc_pkg::CMD_RD_OUT, $urandom_range(0, co - 1), 1'($urandom));
      endcase
    end
    add_word(btc_pkg::CMD_COMPOSE, $urandom_range(0, 4095), 1'($urandom));
    for (int i = 0; i < n_reads / 2; i++)
      add_word(btc_pkg::CMD_RD_OUT, $urandom_range(0, co - 1), 1'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    in_word = '0;
    cfg_index = btc_pkg::REG_CHAIN_LENGTH;
    cfg_data = '0;
    issued = 0;
    received = 0;
    errors = 0;
    cyc = 0;
    p_len = 4; p_r1 = 2; p_r2 = 2;
    g_len = 4; g_r1 = 2; g_r2 = 2;
    g_items = 0;

    // directed: bounds at reset layout, saturation at both ends, fixed patterns
    add_word(btc_pkg::CMD_WR_FIRST, 4095, 1'b1);
    add_word(btc_pkg::CMD_WR_SECOND, cells_of(4, 2), 1'b0);
    add_word(btc_pkg::CMD_RD_OUT, cells_of(4, 4), 1'b1);
    add_word(btc_pkg::CMD_WR_FIRST, cells_of(4, 2) - 1, 1'b0);
    add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'd0);
    add_cfg(btc_pkg::REG_FIRST_RANK, 8'd0);
    add_cfg(btc_pkg::REG_SECOND_RANK, 8'd0);
    run_phase(1, 4);
    run_phase(2, 4);
    add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'hff);
    add_cfg(btc_pkg::REG_FIRST_RANK, 8'hff);
    add_cfg(btc_pkg::REG_SECOND_RANK, 8'hff);
    run_phase(0, 30);
    add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'd31);
    add_cfg(btc_pkg::REG_FIRST_RANK, 8'd3);

    while (g_items < 1850) begin
      if ($urandom_range(0, 7) == 0) add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'($urandom));
      else add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'($urandom_range(4, 6)));
      add_cfg(btc_pkg::REG_FIRST_RANK, 8'($urandom_range(0, 7)) | (8'($urandom) & 8'hf8));
      add_cfg(btc_pkg::REG_SECOND_RANK, 8'($urandom));
      if ($urandom_range(0, 3) == 0) add_drain();
      if (g_len > 8) add_cfg(btc_pkg::REG_CHAIN_LENGTH, 8'($urandom_range(4, 8)));
      run_phase($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0, $urandom_range(10, 40));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (op_q.size() != 0 || start || cfg_valid || issued != received || busy);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
